/* src/spw_pkg.sv */
// Shared types, codes and constants for the sequence-number pending window.
package spw_pkg;

    localparam int NUM_ENTRIES     = 16;
    localparam int IDW             = 4;
    localparam int DEF_SEQ_WIDTH   = 32;
    localparam int MAX_BUCKETS     = 16;

    localparam logic [2:0] FN_ACQUIRE  = 3'd0;
    localparam logic [2:0] FN_RELEASE  = 3'd1;
    localparam logic [2:0] FN_SCHEDULE = 3'd2;
    localparam logic [2:0] FN_PULL     = 3'd3;
    localparam logic [2:0] FN_CANCEL   = 3'd4;
    localparam logic [2:0] FN_DRAIN    = 3'd5;

    localparam logic [1:0] ST_FREE     = 2'd0;
    localparam logic [1:0] ST_DETACHED = 2'd1;
    localparam logic [1:0] ST_PENDING  = 2'd2;

    localparam logic [1:0] RS_OK     = 2'd0;
    localparam logic [1:0] RS_NONE   = 2'd1;
    localparam logic [1:0] RS_MISUSE = 2'd2;

    typedef struct packed {
        logic [2:0]  func;
        logic [3:0]  entry_id;
        logic [31:0] seq_number;
        logic [4:0]  start_slot;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] entry_out;
        logic [4:0] next_slot;
        logic [4:0] pending_count;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_WALK_START,
        S_WALK,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic load;
        logic mod_step;
        logic walk_start;
        logic walk_step;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_need_mod;
        logic is_pull;
        logic mod_last;
        logic need_walk;
        logic walk_stop;
        logic out_free;
    } t_sts;

endpackage

/* src/spw_ctrl.sv */
// Controller state machine sequencing one request through the datapath.
module spw_ctrl import spw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_ready
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_sts.in_valid) begin
                    n_state = i_sts.in_need_mod ? S_MOD : S_EXEC;
                end
            end
            S_MOD: begin
                if (i_sts.mod_last) begin
                    n_state = i_sts.is_pull ? S_WALK_START : S_EXEC;
                end
            end
            S_WALK_START: begin
                n_state = i_sts.need_walk ? S_WALK : S_EXEC;
            end
            S_WALK: begin
                if (i_sts.walk_stop) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_sts.in_valid;
            end
            S_MOD:        o_cmd.mod_step   = 1'b1;
            S_WALK_START: o_cmd.walk_start = i_sts.need_walk;
            S_WALK:       o_cmd.walk_step  = 1'b1;
            S_EXEC:       o_cmd.exec       = i_sts.out_free;
            default:      o_cmd            = '0;
        endcase
    end

endmodule

/* src/spw_dp.sv */
// Datapath: entry pool, chains, remainder unit, chain walker and result register.
module spw_dp import spw_pkg::*; #(
    parameter int SEQ_WIDTH = DEF_SEQ_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_in        i_in_data,
    input  logic       i_out_ready,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_data,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    output logic       o_out_valid,
    output t_out       o_out_data
);

    localparam int SEQ_PAD   = ((SEQ_WIDTH + 3) / 4) * 4;
    localparam int MOD_STEPS = SEQ_PAD / 4;
    localparam int MOD_CW    = $clog2(MOD_STEPS + 1);

    // pool state
    logic [1:0]           r_est  [NUM_ENTRIES];
    logic [SEQ_WIDTH-1:0] r_eseq [NUM_ENTRIES];
    logic [IDW-1:0]       r_ebkt [NUM_ENTRIES];
    logic [IDW-1:0]       r_nxt  [NUM_ENTRIES];
    logic [IDW-1:0]       r_prv  [NUM_ENTRIES];
    logic [IDW-1:0]       r_bhead[MAX_BUCKETS];
    logic [IDW-1:0]       r_btail[MAX_BUCKETS];
    logic [MAX_BUCKETS-1:0] r_bne;
    logic [IDW-1:0]       r_fhead, r_ftail;
    logic                 r_fne;
    logic [4:0]           r_pending;
    logic [4:0]           r_bc;

    logic [1:0]           n_est  [NUM_ENTRIES];
    logic [SEQ_WIDTH-1:0] n_eseq [NUM_ENTRIES];
    logic [IDW-1:0]       n_ebkt [NUM_ENTRIES];
    logic [IDW-1:0]       n_nxt  [NUM_ENTRIES];
    logic [IDW-1:0]       n_prv  [NUM_ENTRIES];
    logic [IDW-1:0]       n_bhead[MAX_BUCKETS];
    logic [IDW-1:0]       n_btail[MAX_BUCKETS];
    logic [MAX_BUCKETS-1:0] n_bne;
    logic [IDW-1:0]       n_fhead, n_ftail;
    logic                 n_fne;
    logic [4:0]           n_pending;

    // request
    logic [2:0]           r_func;
    logic [IDW-1:0]       r_id;
    logic [SEQ_WIDTH-1:0] r_seq;
    logic [4:0]           r_start;

    // remainder unit
    logic [SEQ_PAD-1:0]   r_div, n_div;
    logic [4:0]           r_rem, n_rem;
    logic [MOD_CW-1:0]    r_cnt;

    // chain walker
    logic [IDW-1:0]       r_cur;
    logic                 r_found;

    logic                 r_out_valid;
    t_out                 r_out, n_out;

    logic [63:0]          in_seq_ext;
    logic [SEQ_WIDTH-1:0] in_seq;
    logic [SEQ_PAD-1:0]   in_seq_pad;
    logic [IDW-1:0]       bkt;
    logic                 walk_hit, walk_end;

    assign in_seq_ext = {32'b0, i_in_data.seq_number};
    assign in_seq     = in_seq_ext[SEQ_WIDTH-1:0];
    assign in_seq_pad = SEQ_PAD'(in_seq);
    assign bkt        = r_rem[IDW-1:0];
    assign walk_hit   = (r_eseq[r_cur] == r_seq);
    assign walk_end   = (r_cur == r_btail[bkt]);

    assign o_sts.in_valid    = i_in_valid;
    assign o_sts.in_need_mod = (i_in_data.func == FN_SCHEDULE) || (i_in_data.func == FN_PULL);
    assign o_sts.is_pull     = (r_func == FN_PULL);
    assign o_sts.mod_last    = (r_cnt == MOD_CW'(MOD_STEPS - 1));
    assign o_sts.need_walk   = (r_pending != 5'd0) && r_bne[bkt];
    assign o_sts.walk_stop   = walk_hit || walk_end;
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // four restoring remainder steps per cycle
    always_comb begin
        logic [4:0] rem;
        rem = r_rem;
        for (int k = 0; k < 4; k++) begin
            rem = {rem[3:0], r_div[SEQ_PAD-1-k]};
            if (rem >= r_bc) begin
                rem = rem - r_bc;
            end
        end
        n_rem = rem;
        n_div = r_div << 4;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_in_data.func;
            r_id    <= i_in_data.entry_id;
            r_seq   <= in_seq;
            r_start <= i_in_data.start_slot;
            r_div   <= in_seq_pad;
            r_rem   <= 5'd0;
            r_cnt   <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.mod_step) begin
            r_div <= n_div;
            r_rem <= n_rem;
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.walk_start) begin
            r_cur <= r_bhead[bkt];
        end else if (i_cmd.walk_step) begin
            if (walk_hit) begin
                r_found <= 1'b1;
            end else if (!walk_end) begin
                r_cur <= r_nxt[r_cur];
            end
        end
    end

    // operation
    always_comb begin
        logic           up_en;
        logic [IDW-1:0] up_e;
        logic [IDW-1:0] ub;
        logic [IDW-1:0] e;
        logic [IDW-1:0] ds;
        logic           dfound;

        n_est = r_est;   n_eseq = r_eseq; n_ebkt = r_ebkt;
        n_nxt = r_nxt;   n_prv = r_prv;
        n_bhead = r_bhead; n_btail = r_btail; n_bne = r_bne;
        n_fhead = r_fhead; n_ftail = r_ftail; n_fne = r_fne;
        n_pending = r_pending;
        n_out = '0;
        n_out.status = RS_MISUSE;
        up_en = 1'b0;
        up_e  = '0;
        e     = r_id;
        ds    = '0;
        dfound = 1'b0;

        for (int i = MAX_BUCKETS - 1; i >= 0; i--) begin
            if ((5'(i) >= r_start) && (5'(i) < r_bc) && r_bne[i]) begin
                ds     = IDW'(i);
                dfound = 1'b1;
            end
        end

        case (r_func)
            FN_ACQUIRE: begin
                if (r_fne) begin
                    n_out.entry_out = r_fhead;
                    n_out.status    = RS_OK;
                    n_est[r_fhead]  = ST_DETACHED;
                    if (r_ftail == r_fhead) begin
                        n_fne = 1'b0;
                    end else begin
                        n_fhead = r_nxt[r_fhead];
                    end
                end else begin
                    n_out.status = RS_NONE;
                end
            end
            FN_RELEASE: begin
                if (r_est[e] == ST_DETACHED) begin
                    n_est[e] = ST_FREE;
                    if (r_fne) begin
                        n_nxt[e]       = r_fhead;
                        n_prv[r_fhead] = e;
                    end else begin
                        n_ftail = e;
                    end
                    n_fhead = e;
                    n_fne   = 1'b1;
                    n_out.status = RS_OK;
                end
            end
            FN_SCHEDULE: begin
                if ((r_est[e] == ST_DETACHED) && (r_pending < r_bc)) begin
                    n_est[e]  = ST_PENDING;
                    n_eseq[e] = r_seq;
                    n_ebkt[e] = bkt;
                    n_pending = r_pending + 5'd1;
                    if (r_bne[bkt]) begin
                        n_prv[e]            = r_btail[bkt];
                        n_nxt[r_btail[bkt]] = e;
                    end else begin
                        n_bhead[bkt] = e;
                    end
                    n_btail[bkt] = e;
                    n_bne[bkt]   = 1'b1;
                    n_out.status = RS_OK;
                end
            end
            FN_PULL: begin
                if (r_pending != 5'd0) begin
                    n_out.status = RS_NONE;
                    if (r_found) begin
                        up_en = 1'b1;
                        up_e  = r_cur;
                        n_out.entry_out = r_cur;
                        n_out.status    = RS_OK;
                    end
                end
            end
            FN_CANCEL: begin
                if (r_est[e] == ST_PENDING) begin
                    up_en = 1'b1;
                    up_e  = e;
                    n_out.status = RS_OK;
                end else if (r_est[e] != ST_FREE) begin
                    n_out.status = RS_NONE;
                end
            end
            FN_DRAIN: begin
                if (r_start <= r_bc) begin
                    n_out.status    = RS_NONE;
                    n_out.next_slot = r_start;
                    if (r_pending != 5'd0) begin
                        if (dfound) begin
                            up_en = 1'b1;
                            up_e  = r_bhead[ds];
                            n_out.entry_out = r_bhead[ds];
                            n_out.status    = RS_OK;
                            n_out.next_slot = 5'(ds);
                        end else begin
                            n_out.next_slot = r_bc;
                        end
                    end
                end
            end
            default: n_out.status = RS_MISUSE;
        endcase

        // take a pending entry out of its bucket
        ub = r_ebkt[up_e];
        if (up_en) begin
            n_est[up_e] = ST_DETACHED;
            n_pending   = r_pending - 5'd1;
            if ((r_bhead[ub] == up_e) && (r_btail[ub] == up_e)) begin
                n_bne[ub] = 1'b0;
            end else if (r_bhead[ub] == up_e) begin
                n_bhead[ub] = r_nxt[up_e];
            end else if (r_btail[ub] == up_e) begin
                n_btail[ub] = r_prv[up_e];
            end else begin
                n_nxt[r_prv[up_e]] = r_nxt[up_e];
                n_prv[r_nxt[up_e]] = r_prv[up_e];
            end
        end
        n_out.pending_count = n_pending;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                r_est[i] <= ST_FREE;
                r_nxt[i] <= IDW'((i + 1) % NUM_ENTRIES);
                r_prv[i] <= IDW'((i + NUM_ENTRIES - 1) % NUM_ENTRIES);
            end
            r_bne       <= '0;
            r_fhead     <= '0;
            r_ftail     <= IDW'(NUM_ENTRIES - 1);
            r_fne       <= 1'b1;
            r_pending   <= 5'd0;
            r_bc        <= 5'(MAX_BUCKETS);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_est     <= n_est;
                r_nxt     <= n_nxt;
                r_prv     <= n_prv;
                r_bne     <= n_bne;
                r_fhead   <= n_fhead;
                r_ftail   <= n_ftail;
                r_fne     <= n_fne;
                r_pending <= n_pending;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // ignore writes while anything is pending; clamp to legal range
            if (i_cfg_we && (r_pending == 5'd0)) begin
                if (i_cfg_data == 5'd0) begin
                    r_bc <= 5'd1;
                end else if (i_cfg_data > 5'(MAX_BUCKETS)) begin
                    r_bc <= 5'(MAX_BUCKETS);
                end else begin
                    r_bc <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_eseq  <= n_eseq;
            r_ebkt  <= n_ebkt;
            r_bhead <= n_bhead;
            r_btail <= n_btail;
            r_out   <= n_out;
        end
    end

endmodule

/* src/seqno_pending_window_core.sv */
// Acquire, release, cancel, drain and unknown codes go from accept straight to the
// execute state; schedule first runs the remainder unit (4 bits a cycle) over the
// padded sequence number; pull also loads the chain walker and visits its bucket's chain.
// One request at a time; the next is accepted the cycle after the result is
// registered, and a held result stalls the next request.
// Reset is synchronous, active low: entries free in id order, buckets empty, bucket_count 16.
module seqno_pending_window_core import spw_pkg::*; #(
    parameter int SEQ_WIDTH = DEF_SEQ_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in        i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out       o_out_data,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    spw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (o_in_ready)
    );

    spw_dp #(
        .SEQ_WIDTH (SEQ_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

/* sim/seqno_pending_window_core_test.sv */
// Self-checking testbench for the sequence-number pending window core.
module seqno_pending_window_core_test import spw_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FREE_CHAIN = 16;

    class window_scoreboard;
        logic [1:0]  ent_state [NUM_ENTRIES];
        logic [31:0] ent_seq   [NUM_ENTRIES];
        logic [3:0]  nxt       [NUM_ENTRIES];
        logic [3:0]  prv       [NUM_ENTRIES];
        logic [3:0]  hd        [17];
        logic [3:0]  tl        [17];
        logic        busy      [17];
        logic [31:0] bcount;
        int          ptotal;
        t_out        awaited [$];
        int          errors;

        function new();
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                ent_state[i] = ST_FREE;
                ent_seq[i]   = '0;
                nxt[i]       = 4'(i + 1);
                prv[i]       = 4'(i + NUM_ENTRIES - 1);
            end
            for (int c = 0; c < 17; c++) begin
                hd[c] = '0;
                tl[c] = '0;
                busy[c] = 1'b0;
            end
            tl[FREE_CHAIN] = 4'd15;
            busy[FREE_CHAIN] = 1'b1;
            bcount = MAX_BUCKETS;
            ptotal = 0;
            errors = 0;
        endfunction

        function void push_front(int c, logic [3:0] e);
            if (busy[c]) begin
                nxt[e] = hd[c];
                prv[hd[c]] = e;
            end else begin
                tl[c] = e;
            end
            hd[c] = e;
            busy[c] = 1'b1;
        endfunction

        function void push_back(int c, logic [3:0] e);
            if (busy[c]) begin
                prv[e] = tl[c];
                nxt[tl[c]] = e;
            end else begin
                hd[c] = e;
            end
            tl[c] = e;
            busy[c] = 1'b1;
        endfunction

        function void unlink(int c, logic [3:0] e);
            if (hd[c] == e && tl[c] == e) begin
                busy[c] = 1'b0;
            end else if (hd[c] == e) begin
                hd[c] = nxt[e];
            end else if (tl[c] == e) begin
                tl[c] = prv[e];
            end else begin
                nxt[prv[e]] = nxt[e];
                prv[nxt[e]] = prv[e];
            end
        endfunction

        function void unpend(logic [3:0] e);
            unlink(int'(ent_seq[e] % bcount), e);
            ent_state[e] = ST_DETACHED;
            ptotal--;
        endfunction

        function void write_bucket_count(logic [4:0] v);
            if (ptotal != 0) return;
            if (v < 1) bcount = 1;
            else if (v > MAX_BUCKETS) bcount = MAX_BUCKETS;
            else bcount = v;
        endfunction

        function void note_request(t_in r);
            t_out        res;
            logic [3:0]  e;
            logic [3:0]  cur;
            int          b;
            int          s;
            res = '0;
            res.status = RS_MISUSE;
            e = r.entry_id;
            case (r.func)
                FN_ACQUIRE: begin
                    if (busy[FREE_CHAIN]) begin
                        res.entry_out = hd[FREE_CHAIN];
                        unlink(FREE_CHAIN, hd[FREE_CHAIN]);
                        ent_state[res.entry_out] = ST_DETACHED;
                        res.status = RS_OK;
                    end else begin
                        res.status = RS_NONE;
                    end
                end
                FN_RELEASE: begin
                    if (ent_state[e] == ST_DETACHED) begin
                        ent_state[e] = ST_FREE;
                        push_front(FREE_CHAIN, e);
                        res.status = RS_OK;
                    end
                end
                FN_SCHEDULE: begin
                    if (ent_state[e] == ST_DETACHED && ptotal < bcount) begin
                        ent_state[e] = ST_PENDING;
                        ent_seq[e] = r.seq_number;
                        ptotal++;
                        push_back(int'(r.seq_number % bcount), e);
                        res.status = RS_OK;
                    end
                end
                FN_PULL: begin
                    if (ptotal != 0) begin
                        b = int'(r.seq_number % bcount);
                        res.status = RS_NONE;
                        if (busy[b]) begin
                            cur = hd[b];
                            for (int k = 0; k < NUM_ENTRIES; k++) begin
                                if (ent_seq[cur] == r.seq_number) begin
                                    unpend(cur);
                                    res.entry_out = cur;
                                    res.status = RS_OK;
                                    break;
                                end
                                if (cur == tl[b]) break;
                                cur = nxt[cur];
                            end
                        end
                    end
                end
                FN_CANCEL: begin
                    if (ent_state[e] == ST_PENDING) begin
                        unpend(e);
                        res.status = RS_OK;
                    end else if (ent_state[e] == ST_DETACHED) begin
                        res.status = RS_NONE;
                    end
                end
                FN_DRAIN: begin
                    if (r.start_slot <= bcount) begin
                        res.status = RS_NONE;
                        res.next_slot = r.start_slot;
                        if (ptotal != 0) begin
                            for (s = int'(r.start_slot); s < int'(bcount); s++)
                                if (busy[s]) break;
                            if (s < int'(bcount)) begin
                                res.entry_out = hd[s];
                                unpend(hd[s]);
                                res.status = RS_OK;
                            end
                            res.next_slot = 5'(s);
                        end
                    end
                end
                default: ;
            endcase
            res.pending_count = 5'(ptotal);
            awaited.push_back(res);
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status || got.entry_out !== want.entry_out ||
                got.next_slot !== want.next_slot ||
                got.pending_count !== want.pending_count) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: want st=%0d id=%0d slot=%0d cnt=%0d, ",
                              "got st=%0d id=%0d slot=%0d cnt=%0d"},
                             want.status, want.entry_out, want.next_slot,
                             want.pending_count, got.status, got.entry_out,
                             got.next_slot, got.pending_count);
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    t_in        i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b1;
    t_out       o_out_data;
    logic       i_cfg_we = 1'b0;
    logic [4:0] i_cfg_data = '0;
    logic       quiet = 1'b0;

    window_scoreboard sb = new();

    seqno_pending_window_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_data);
    end

    // Result-side back-pressure in random bursts.
    initial begin
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic send_request(t_in r);
        i_in_data  <= r;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(r);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_buckets(logic [4:0] v);
        settle();
        i_cfg_data <= v;
        i_cfg_we   <= 1'b1;
        @(posedge i_clk);
        sb.write_bucket_count(v);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_in make_req(logic [2:0] f, logic [3:0] id, logic [31:0] sq,
                                     logic [4:0] st);
        t_in r;
        r.func = f;
        r.entry_id = id;
        r.seq_number = sq;
        r.start_slot = st;
        return r;
    endfunction

    function automatic logic [3:0] pick_entry(logic [1:0] want);
        int base;
        base = $urandom_range(0, 15);
        for (int k = 0; k < NUM_ENTRIES; k++)
            if (sb.ent_state[(base + k) % NUM_ENTRIES] == want)
                return 4'((base + k) % NUM_ENTRIES);
        return 4'($urandom);
    endfunction

    function automatic logic [31:0] pick_seq();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'hFFFF_FFFF;
            2: return sb.bcount * $urandom_range(0, 5);
            default: return $urandom_range(0, 40);
        endcase
    endfunction

    function automatic t_in random_req();
        t_in r;
        int  k;
        r = make_req(3'($urandom), 4'($urandom), $urandom, 5'($urandom));
        k = $urandom_range(0, 99);
        if (k < 14) begin
            r.func = FN_ACQUIRE;
        end else if (k < 24) begin
            r.func = FN_RELEASE;
            if ($urandom_range(0, 3) != 0) r.entry_id = pick_entry(ST_DETACHED);
        end else if (k < 50) begin
            r.func = FN_SCHEDULE;
            if ($urandom_range(0, 5) != 0) r.entry_id = pick_entry(ST_DETACHED);
            r.seq_number = pick_seq();
        end else if (k < 68) begin
            r.func = FN_PULL;
            if (sb.ptotal != 0 && $urandom_range(0, 4) != 0)
                r.seq_number = sb.ent_seq[pick_entry(ST_PENDING)];
            else
                r.seq_number = pick_seq();
        end else if (k < 80) begin
            r.func = FN_CANCEL;
            if ($urandom_range(0, 3) != 0) r.entry_id = pick_entry(ST_PENDING);
        end else if (k < 96) begin
            r.func = FN_DRAIN;
            if ($urandom_range(0, 7) != 0) r.start_slot = 5'($urandom_range(0, sb.bcount));
        end else begin
            r.func = 3'($urandom_range(6, 7));
        end
        return r;
    endfunction

    initial begin
        logic [4:0] settings [10];
        settings = '{5'd16, 5'd0, 5'd1, 5'd2, 5'd31, 5'd3, 5'd5, 5'd7, 5'd16, 5'd16};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: misuse with nothing pending, extremes, limit on pending entries.
        send_request(make_req(FN_PULL, 4'd0, 32'd0, 5'd0));
        send_request(make_req(FN_DRAIN, 4'd0, 32'd0, 5'd3));
        send_request(make_req(FN_DRAIN, 4'd0, 32'd0, 5'd17));
        send_request(make_req(FN_RELEASE, 4'd15, 32'd0, 5'd0));
        send_request(make_req(FN_CANCEL, 4'd15, 32'd0, 5'd0));
        send_request(make_req(FN_SCHEDULE, 4'd3, 32'd5, 5'd0));
        send_request(make_req(3'd6, 4'd0, 32'd0, 5'd0));
        send_request(make_req(3'd7, 4'd15, 32'hFFFF_FFFF, 5'd31));
        send_request(make_req(FN_ACQUIRE, 4'd0, 32'd0, 5'd0));
        send_request(make_req(FN_ACQUIRE, 4'd0, 32'd0, 5'd0));
        send_request(make_req(FN_CANCEL, 4'd1, 32'd0, 5'd0));
        send_request(make_req(FN_SCHEDULE, 4'd0, 32'hFFFF_FFFF, 5'd0));
        send_request(make_req(FN_SCHEDULE, 4'd1, 32'd15, 5'd0));
        send_request(make_req(FN_PULL, 4'd0, 32'd31, 5'd0));
        send_request(make_req(FN_PULL, 4'd0, 32'd15, 5'd0));
        send_request(make_req(FN_DRAIN, 4'd0, 32'd0, 5'd16));
        send_request(make_req(FN_DRAIN, 4'd0, 32'd0, 5'd0));
        send_request(make_req(FN_RELEASE, 4'd0, 32'd0, 5'd0));
        // Written while nothing is pending but entry 1 stays detached.
        write_buckets(5'd1);
        send_request(make_req(FN_SCHEDULE, 4'd1, 32'd9, 5'd0));
        send_request(make_req(FN_ACQUIRE, 4'd0, 32'd0, 5'd0));
        send_request(make_req(FN_SCHEDULE, 4'd0, 32'd9, 5'd0));
        // Ignored: an entry is pending.
        write_buckets(5'd8);
        send_request(make_req(FN_DRAIN, 4'd0, 32'd0, 5'd1));
        send_request(make_req(FN_DRAIN, 4'd0, 32'd0, 5'd0));
        for (int a = 0; a < 16; a++)
            send_request(make_req(FN_ACQUIRE, 4'($urandom), $urandom, 5'd0));

        for (int p = 0; p < 10; p++) begin
            if (p == 9) quiet = 1'b1;
            // Leave entries pending before one write so that it is dropped.
            if (p != 4)
                while (sb.ptotal != 0) send_request(make_req(FN_DRAIN, 4'd0, 32'd0, 5'd0));
            write_buckets(settings[p]);
            for (int n = 0; n < 160; n++) send_request(random_req());
        end
        settle();
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

endmodule
